>>> hdl/acz_pkg.sv
// shared constants and types for the ac zero run-length encoder
// no dependencies; used by every module of the block
package acz_pkg;

  localparam int COEFF_BITS_DEF = 12;
  localparam int RUN_W          = 4;
  localparam int POS_W          = 6;
  // run_length, last_of_item, block_done beside the level
  localparam int PAIR_EXTRA_W   = RUN_W + 2;

  localparam logic [POS_W-1:0] FIRST_POS = POS_W'(1);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(63);
  localparam logic [RUN_W-1:0] RUN_MAX   = RUN_W'(15);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  // room for the two pairs one coefficient can cause
  localparam int FIFO_ROOM  = FIFO_DEPTH - 2;

  // write strobes from the pair generator into the output queue
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

>>> hdl/ac_zero_run_length_encoder.sv
// path: an accepted coefficient beat waits in the input register until the queue has room
// for two pairs, is then written to the output queue, and its first pair is offered from there
// throughput: one coefficient per cycle while the four-entry queue holds two or fewer
// pairs; a coefficient causes up to two pairs, the output gives one per cycle while out_ready is high
// reset: synchronous active-low rst_n empties the queue and returns the block
// position to the first ac coefficient with no pending zero run
module ac_zero_run_length_encoder #(
  parameter int COEFF_BITS = acz_pkg::COEFF_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COEFF_BITS-1:0] in_coefficient,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_run_length,
  output logic [COEFF_BITS-1:0] out_level,
  output logic                  out_last_of_item,
  output logic                  out_block_done
);

  localparam int PAIR_W = COEFF_BITS + acz_pkg::PAIR_EXTRA_W;

  logic                  q_valid, take, has_room;
  logic [COEFF_BITS-1:0] q_coeff;
  acz_pkg::push_t        push;
  logic [PAIR_W-1:0]     w0, w1, out_data;

  // advance the input register when the queue can take two pairs
  assign take = q_valid && has_room;

  acz_in_reg #(.COEFF_BITS(COEFF_BITS)) u_in_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_coefficient (in_coefficient),
    .take           (take),
    .q_valid        (q_valid),
    .q_coeff        (q_coeff)
  );

  acz_pair_gen #(.COEFF_BITS(COEFF_BITS)) u_pair_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (take),
    .coeff (q_coeff),
    .push  (push),
    .w0    (w0),
    .w1    (w1)
  );

  acz_out_fifo #(.WIDTH(PAIR_W)) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .w0        (w0),
    .w1        (w1),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // unpack {run_length, level, last_of_item, block_done}
  assign out_run_length   = out_data[PAIR_W-1 -: acz_pkg::RUN_W];
  assign out_level        = out_data[COEFF_BITS+1:2];
  assign out_last_of_item = out_data[1];
  assign out_block_done   = out_data[0];

endmodule

>>> hdl/acz_in_reg.sv
// input register stage: holds one coefficient beat for the pair generator
// depends on acz_pkg
module acz_in_reg #(
  parameter int COEFF_BITS = acz_pkg::COEFF_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COEFF_BITS-1:0] in_coefficient,
  input  logic                  take,
  output logic                  q_valid,
  output logic [COEFF_BITS-1:0] q_coeff
);

  logic                  valid_r, valid_nxt;
  logic [COEFF_BITS-1:0] coeff_r;

  // empty or draining this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      coeff_r <= in_coefficient;
    end
  end

  assign q_valid = valid_r;
  assign q_coeff = coeff_r;

endmodule

>>> hdl/acz_pair_gen.sv
// pair generator: block position, zero-run count and up to two pairs per beat
// depends on acz_pkg
module acz_pair_gen #(
  parameter int COEFF_BITS = acz_pkg::COEFF_BITS_DEF,
  localparam int PAIR_W    = COEFF_BITS + acz_pkg::PAIR_EXTRA_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [COEFF_BITS-1:0] coeff,
  output acz_pkg::push_t        push,
  output logic [PAIR_W-1:0]     w0,
  output logic [PAIR_W-1:0]     w1
);

  logic [acz_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [acz_pkg::RUN_W-1:0] run_r, run_nxt;
  logic                      saw_r, saw_nxt;

  logic nz, at_end, run_full, p0_valid, eob_valid;
  logic [acz_pkg::RUN_W-1:0] p0_run;
  logic [COEFF_BITS-1:0]     p0_level;

  assign nz       = (coeff != '0);
  assign at_end   = (pos_r >= acz_pkg::LAST_POS);
  assign run_full = (run_r == acz_pkg::RUN_MAX);

  // first pair: nonzero coefficient, or sixteenth zero of a run
  assign p0_valid  = nz || run_full;
  assign p0_run    = nz ? run_r : acz_pkg::RUN_MAX;
  assign p0_level  = nz ? coeff : '0;
  // end-of-block unless all coefficients were nonzero
  assign eob_valid = at_end && (saw_r || !nz);

  // pack pairs as {run_length, level, last_of_item, block_done}
  always_comb begin
    push.push0 = fire && (p0_valid || eob_valid);
    push.push1 = fire && p0_valid && eob_valid;
    if (p0_valid) begin
      w0 = {p0_run, p0_level, !eob_valid, at_end && !eob_valid};
    end else begin
      w0 = {{acz_pkg::RUN_W{1'b0}}, {COEFF_BITS{1'b0}}, 1'b1, 1'b1};
    end
    w1 = {{acz_pkg::RUN_W{1'b0}}, {COEFF_BITS{1'b0}}, 1'b1, 1'b1};
  end

  // block counters, back to reset values after the last position
  always_comb begin
    pos_nxt = pos_r;
    run_nxt = run_r;
    saw_nxt = saw_r;
    if (fire) begin
      if (at_end) begin
        pos_nxt = acz_pkg::FIRST_POS;
        run_nxt = '0;
        saw_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + acz_pkg::POS_W'(1);
        saw_nxt = saw_r || !nz;
        if (nz || run_full) begin
          run_nxt = '0;
        end else begin
          run_nxt = run_r + acz_pkg::RUN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= acz_pkg::FIRST_POS;
      run_r <= '0;
      saw_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      run_r <= run_nxt;
      saw_r <= saw_nxt;
    end
  end

endmodule

>>> hdl/acz_out_fifo.sv
// output queue of result pairs: takes up to two pairs a beat, gives one
// depends on acz_pkg
module acz_out_fifo #(
  parameter int WIDTH = acz_pkg::COEFF_BITS_DEF + acz_pkg::PAIR_EXTRA_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  acz_pkg::push_t     push,
  input  logic [WIDTH-1:0]   w0,
  input  logic [WIDTH-1:0]   w1,
  output logic               has_room,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WIDTH-1:0]   out_data
);

  logic [WIDTH-1:0]            mem_r [acz_pkg::FIFO_DEPTH];
  logic [acz_pkg::FIFO_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [acz_pkg::FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic                        pop;
  logic [acz_pkg::FIFO_AW-1:0] wr_p1;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign has_room  = (cnt_r <= acz_pkg::FIFO_CW'(acz_pkg::FIFO_ROOM));
  assign wr_p1     = wr_r + acz_pkg::FIFO_AW'(1);

  // pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    if (push.push1) begin
      wr_nxt = wr_r + acz_pkg::FIFO_AW'(2);
    end else if (push.push0) begin
      wr_nxt = wr_p1;
    end
    rd_nxt  = pop ? rd_r + acz_pkg::FIFO_AW'(1) : rd_r;
    cnt_nxt = cnt_r + acz_pkg::FIFO_CW'(push.push0) + acz_pkg::FIFO_CW'(push.push1)
            - acz_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_r] <= w0;
    end
    if (push.push1) begin
      mem_r[wr_p1] <= w1;
    end
  end

endmodule

>>> hdl/acz_checker.sv
// port-level checks on the ac zero run-length encoder
// depends on acz_pkg; bound to ac_zero_run_length_encoder below
module acz_checker #(
  parameter int COEFF_BITS = acz_pkg::COEFF_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [3:0]            out_run_length,
  input logic [COEFF_BITS-1:0] out_level,
  input logic                  out_last_of_item,
  input logic                  out_block_done
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_run_length)
      && $stable(out_level) && $stable(out_last_of_item) && $stable(out_block_done))
    else $error("result beat changed while stalled");

  // the block's final pair is always the final pair of its coefficient
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_done |-> out_last_of_item)
    else $error("block_done without last_of_item");

  // a zero level is either a sixteen-zero run or end-of-block
  a_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_level == '0 |-> out_run_length == 4'd15 || out_run_length == 4'd0)
    else $error("zero level with odd run length");

  // end-of-block pair closes the block
  a_eob_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_level == '0 && out_run_length == 4'd0 |-> out_block_done)
    else $error("end-of-block pair without block_done");

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ac_zero_run_length_encoder acz_checker #(.COEFF_BITS(COEFF_BITS)) u_acz_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_run_length   (out_run_length),
  .out_level        (out_level),
  .out_last_of_item (out_last_of_item),
  .out_block_done   (out_block_done)
);
